>>> hw/rtl/sha256_pkg.sv
// sha256 hasher package: payload types, constants and round functions
package sha256_pkg;

	typedef struct packed {
		logic [31:0] message_word;
		logic [2:0]  valid_bytes;
		logic        message_end;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  digest_index;
		logic        digest_last;
	} out_item_t;

	typedef logic [31:0] word_t;

	localparam word_t PAD_WORD = 32'h8000_0000;

	function automatic word_t init_hash(input logic [2:0] i);
		case (i)
			3'd0: init_hash = 32'h6a09e667;
			3'd1: init_hash = 32'hbb67ae85;
			3'd2: init_hash = 32'h3c6ef372;
			3'd3: init_hash = 32'ha54ff53a;
			3'd4: init_hash = 32'h510e527f;
			3'd5: init_hash = 32'h9b05688c;
			3'd6: init_hash = 32'h1f83d9ab;
			default: init_hash = 32'h5be0cd19;
		endcase
	endfunction

	function automatic word_t round_const(input logic [5:0] t);
		word_t k [64];
		k = '{
			32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
			32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
			32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
			32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
			32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
			32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
			32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
			32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
			32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
			32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
			32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
			32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
			32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		round_const = k[t];
	endfunction

	function automatic word_t rotr(input word_t x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage

>>> hw/rtl/sha256_message_hasher_core.sv
// sha-256 message hasher top level: sequencer, schedule window and chaining value
// a plain word is taken while idle; the 16th word of a block starts 64 rounds,
// one round of the shared unit a cycle, then a fold into the chaining value
// an end word adds padding words, one or two compressions, then
// eight digest transfers at one per cycle while out stall is low
// input stalls unless idle: no word is taken during rounds, fold, padding or output
// arst_n clears the sequencer, bit counter and slot; chaining value loads the iv
module sha256_message_hasher_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  sha256_pkg::in_item_t  in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output sha256_pkg::out_item_t out_data
);
	// sequencer codes
	localparam logic [2:0] ST_IDLE  = 3'd0;  // taking message words
	localparam logic [2:0] ST_ROUND = 3'd1;  // 64 rounds
	localparam logic [2:0] ST_FOLD  = 3'd2;  // add into chaining value
	localparam logic [2:0] ST_PAD   = 3'd3;  // push padding / length words
	localparam logic [2:0] ST_OUT   = 3'd4;  // emit digest

	logic [2:0]  state_q;
	logic [63:0] bit_count_q;
	logic [3:0]  slot_q;
	logic [5:0]  round_q;
	logic [2:0]  out_idx_q;
	logic        padding_q;   // message end seen, padding in progress
	logic        pad80_q;     // 0x80 word still to push
	logic        lenhi_q;     // high length word went into slot 14 last cycle
	logic        lenout_q;    // length word written, this block is the final one
	sha256_pkg::word_t chain_q [8];
	sha256_pkg::word_t vars_q  [8];
	sha256_pkg::word_t win_q   [16];

	sha256_pkg::word_t w_new;
	sha256_pkg::word_t v_new [8];
	sha256_pkg::word_t push_w;
	logic              push_en;
	logic [63:0]       bc_next;
	logic              in_fire;
	logic [2:0]        nb;
	sha256_pkg::word_t keep;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign out_valid = (state_q == ST_OUT);
	assign out_data.digest_word  = chain_q[out_idx_q];
	assign out_data.digest_index = out_idx_q;
	assign out_data.digest_last  = (out_idx_q == 3'd7);

	// window is a circular buffer indexed by round mod 16
	sha256_round u_round (
		.v_in(vars_q), .w2(win_q[round_q[3:0] - 4'd2]), .w7(win_q[round_q[3:0] - 4'd7]),
		.w15(win_q[round_q[3:0] - 4'd15]), .w16(win_q[round_q[3:0]]),
		.expand(round_q[5:4] != 2'd0), .t(round_q), .w_out(w_new), .v_out(v_new)
	);

	// word to push into the window this cycle
	// the length goes out only once slot 14 is reached after the pad byte;
	// otherwise what is left of slots 14 and 15 gets zeros and an extra block follows
	always_comb begin
		nb = (in_data.valid_bytes > 3'd4) ? 3'd4 : in_data.valid_bytes;
		keep = (nb == 3'd0) ? 32'h0 : (32'hffff_ffff << (6'd32 - {nb, 3'b000}));
		push_en = 1'b0;
		push_w = '0;
		bc_next = bit_count_q;
		if (in_fire) begin
			push_en = 1'b1;
			if (!in_data.message_end) begin
				push_w = in_data.message_word;
				bc_next = bit_count_q + 64'd32;
			end else begin
				bc_next = bit_count_q + {58'd0, nb, 3'b000};
				if (nb == 3'd4) push_w = in_data.message_word;
				else push_w = (in_data.message_word & keep)
					| (sha256_pkg::PAD_WORD >> {nb, 3'b000});
			end
		end else if (state_q == ST_PAD) begin
			push_en = 1'b1;
			if (pad80_q) push_w = sha256_pkg::PAD_WORD;
			else if (slot_q == 4'd14) push_w = bit_count_q[63:32];
			else if (slot_q == 4'd15 && lenhi_q) push_w = bit_count_q[31:0];
			else push_w = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_count_q <= '0;
			slot_q <= '0;
			round_q <= '0;
			out_idx_q <= '0;
			padding_q <= 1'b0;
			pad80_q <= 1'b0;
			for (int j = 0; j < 8; j++) chain_q[j] <= sha256_pkg::init_hash(3'(j));
		end else begin
			unique case (state_q) inside
				ST_IDLE, ST_PAD: begin
					if (push_en) begin
						slot_q <= slot_q + 4'd1;
						bit_count_q <= bc_next;
						if (state_q == ST_PAD) pad80_q <= 1'b0;
						if (in_fire && in_data.message_end) begin
							padding_q <= 1'b1;
							pad80_q <= (nb == 3'd4);
						end
						if (slot_q == 4'd15) begin
							state_q <= ST_ROUND;
							round_q <= '0;
						end else if (in_fire && in_data.message_end) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63) state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					for (int j = 0; j < 8; j++) chain_q[j] <= chain_q[j] + vars_q[j];
					if (!padding_q) begin
						state_q <= ST_IDLE;
					end else if (!pad80_q && lenout_q) begin
						state_q <= ST_OUT;
						out_idx_q <= '0;
					end else begin
						state_q <= ST_PAD;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						out_idx_q <= out_idx_q + 3'd1;
						if (out_idx_q == 3'd7) begin
							state_q <= ST_IDLE;
							padding_q <= 1'b0;
							bit_count_q <= '0;
							slot_q <= '0;
							for (int j = 0; j < 8; j++)
								chain_q[j] <= sha256_pkg::init_hash(3'(j));
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// length word tracking: high word in slot 14, low word in slot 15 ends the message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lenhi_q <= 1'b0;
			lenout_q <= 1'b0;
		end else begin
			if (state_q == ST_PAD) lenhi_q <= !pad80_q && (slot_q == 4'd14);
			if (state_q == ST_OUT) lenout_q <= 1'b0;
			else if (state_q == ST_PAD && !pad80_q && slot_q == 4'd15 && lenhi_q)
				lenout_q <= 1'b1;
		end
	end

	// schedule window and working variables (payload, no reset)
	always_ff @(posedge clk) begin
		if (push_en && (state_q == ST_IDLE || state_q == ST_PAD)) begin
			win_q[slot_q] <= push_w;
			if (slot_q == 4'd15) for (int j = 0; j < 8; j++) vars_q[j] <= chain_q[j];
		end
		if (state_q == ST_ROUND) begin
			win_q[round_q[3:0]] <= w_new;
			for (int j = 0; j < 8; j++) vars_q[j] <= v_new[j];
		end
	end
endmodule

>>> hw/rtl/sha256_round.sv
// one shared sha-256 round: schedule expansion and compression step
module sha256_round (
	input  sha256_pkg::word_t       v_in  [8],
	input  sha256_pkg::word_t       w2,
	input  sha256_pkg::word_t       w7,
	input  sha256_pkg::word_t       w15,
	input  sha256_pkg::word_t       w16,
	input  logic                    expand,
	input  logic [5:0]              t,
	output sha256_pkg::word_t       w_out,
	output sha256_pkg::word_t       v_out [8]
);
	sha256_pkg::word_t s0, s1, ch, maj, e1, e0, t1, t2;

	always_comb begin
		s1 = sha256_pkg::rotr(w2, 17) ^ sha256_pkg::rotr(w2, 19) ^ (w2 >> 10);
		s0 = sha256_pkg::rotr(w15, 7) ^ sha256_pkg::rotr(w15, 18) ^ (w15 >> 3);
		w_out = expand ? (s1 + w7 + s0 + w16) : w16;
		e1 = sha256_pkg::rotr(v_in[4], 6) ^ sha256_pkg::rotr(v_in[4], 11)
			^ sha256_pkg::rotr(v_in[4], 25);
		ch = (v_in[4] & v_in[5]) ^ (~v_in[4] & v_in[6]);
		e0 = sha256_pkg::rotr(v_in[0], 2) ^ sha256_pkg::rotr(v_in[0], 13)
			^ sha256_pkg::rotr(v_in[0], 22);
		maj = (v_in[0] & v_in[1]) ^ (v_in[0] & v_in[2]) ^ (v_in[1] & v_in[2]);
		t1 = v_in[7] + e1 + ch + sha256_pkg::round_const(t) + w_out;
		t2 = e0 + maj;
		v_out[0] = t1 + t2;
		v_out[1] = v_in[0];
		v_out[2] = v_in[1];
		v_out[3] = v_in[2];
		v_out[4] = v_in[3] + t1;
		v_out[5] = v_in[4];
		v_out[6] = v_in[5];
		v_out[7] = v_in[6];
	end
endmodule

>>> hw/rtl/sha256_checker.sv
// port-level checker for the sha-256 hasher, bound to the top level
module sha256_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input sha256_pkg::out_item_t out_data
);
	// no input taken while a digest is shown
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input open during digest");
	// digest index advances by one per transfer
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !out_data.digest_last) |=>
		(out_valid && out_data.digest_index == $past(out_data.digest_index) + 3'd1))
		else $error("digest index skipped");
	// last flag only on index seven
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.digest_last == (out_data.digest_index == 3'd7)))
		else $error("bad last flag");
	// stalled digest holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_data)))
		else $error("stalled digest changed");
endmodule

bind sha256_message_hasher_core sha256_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
